[design/ptc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes and byte constants for the pan/tilt command controller.
package ptc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int NSLOT       = 6;
   localparam int SLOT_W      = $clog2(NSLOT + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEAD_ZONE,
      REG_GAIN_SWITCH,
      REG_PAN_GAIN_NEAR,
      REG_PAN_GAIN_FAR,
      REG_TILT_GAIN_NEAR,
      REG_TILT_GAIN_FAR,
      REG_PAN_LIMIT,
      REG_TILT_LIMIT
   } csr_reg_type;

   typedef struct packed {
      logic [7:0]  dead_zone;
      logic [7:0]  gain_switch;
      logic [17:0] pan_gain_near;
      logic [17:0] pan_gain_far;
      logic [17:0] tilt_gain_near;
      logic [17:0] tilt_gain_far;
      logic [11:0] pan_speed_limit;
      logic [11:0] tilt_speed_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dead_zone:        8'd10,
      gain_switch:      8'd50,
      pan_gain_near:    18'd100270,
      pan_gain_far:     18'd83558,
      tilt_gain_near:   18'd136367,
      tilt_gain_far:    18'd68183,
      pan_speed_limit:  12'd800,
      tilt_speed_limit: 12'd628
   };

   // frame numbers with special handling
   localparam logic [15:0] FN_IGNORE = 16'd2;
   localparam logic [15:0] FN_PRIME  = 16'd4;

   localparam logic signed [12:0] TURN_STEP = 13'sd10;
   // ceil(2^16 / 5), exact floor(n / 5) for n below 2^14
   localparam logic [14:0] DIV5_RECIP = 15'd13108;

   localparam logic [7:0] BYTE_SYNC  = 8'hFF;
   localparam logic [7:0] BYTE_ADDR  = 8'h30;
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_STOP  = 8'h60;
   localparam logic [7:0] BYTE_PAN   = 8'h50;
   localparam logic [7:0] BYTE_TILT  = 8'h51;
   localparam logic [7:0] BYTE_DIR   = 8'h53;
   localparam logic [7:0] BYTE_END   = 8'hEF;
   localparam logic [7:0] DIR_RIGHT  = 8'h31;
   localparam logic [7:0] DIR_LEFT   = 8'h32;
   localparam logic [7:0] DIR_UP     = 8'h33;
   localparam logic [7:0] DIR_DOWN   = 8'h34;

   typedef enum logic [1:0] {
      FRM_STOP,
      FRM_PAN,
      FRM_TILT,
      FRM_DIR
   } frame_type;

   typedef struct packed {
      logic       en;
      frame_type  kind;
      logic [7:0] code;
   } slot_type;

   typedef struct packed {
      slot_type [NSLOT-1:0] slots;
      logic [11:0]          pan_rate;
      logic [11:0]          tilt_rate;
   } plan_type;

   typedef struct packed {
      logic [10:0] old_x;
      logic [10:0] old_y;
      logic [10:0] new_x;
      logic [10:0] new_y;
      logic [15:0] frame_number;
   } req_type;

   typedef struct packed {
      logic [7:0] command_byte;
      logic       frame_end;
      logic       run_end;
   } rsp_type;

endpackage

[design/ptc_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the pan/tilt command controller.
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] old_x;
   logic [10:0] old_y;
   logic [10:0] new_x;
   logic [10:0] new_y;
   logic [15:0] frame_number;

   modport source (output valid, old_x, old_y, new_x, new_y, frame_number, input ready);
   modport sink (input valid, old_x, old_y, new_x, new_y, frame_number, output ready);
endinterface

interface ptc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] command_byte;
   logic       frame_end;
   logic       run_end;

   modport source (output valid, command_byte, frame_end, run_end, input ready);
   modport sink (input valid, command_byte, frame_end, run_end, output ready);
endinterface

[design/ptc_csr.sv]
`timescale 1ns / 1ps
// Configuration register file of the pan/tilt command controller.
module ptc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ptc_pkg::cfg_type                 cfg
);
   import ptc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_DEAD_ZONE:      cfg_in.dead_zone        = csr_wdata[7:0];
            REG_GAIN_SWITCH:    cfg_in.gain_switch      = csr_wdata[7:0];
            REG_PAN_GAIN_NEAR:  cfg_in.pan_gain_near    = csr_wdata[17:0];
            REG_PAN_GAIN_FAR:   cfg_in.pan_gain_far     = csr_wdata[17:0];
            REG_TILT_GAIN_NEAR: cfg_in.tilt_gain_near   = csr_wdata[17:0];
            REG_TILT_GAIN_FAR:  cfg_in.tilt_gain_far    = csr_wdata[17:0];
            REG_PAN_LIMIT:      cfg_in.pan_speed_limit  = csr_wdata[11:0];
            REG_TILT_LIMIT:     cfg_in.tilt_speed_limit = csr_wdata[11:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/ptc_plan.sv]
`timescale 1ns / 1ps
// Request pipeline: displacement, frame plan, divide by five, gain and limit.
module ptc_plan (
   input  logic              clock,
   input  logic              reset,
   input  ptc_pkg::cfg_type  cfg,
   ptc_req_if.sink           req_bus,
   output logic              plan_valid,
   input  logic              plan_ready,
   output ptc_pkg::plan_type plan
);
   import ptc_pkg::*;

   typedef struct packed {
      logic       stop;
      logic       dir;
      logic [7:0] code;
   } axis_type;

   typedef struct packed {
      slot_type [NSLOT-1:0] slots;
      logic [13:0]          mag_x;
      logic [13:0]          mag_y;
      logic                 far_x;
      logic                 far_y;
   } s2_type;

   typedef struct packed {
      slot_type [NSLOT-1:0] slots;
      logic [11:0]          q_x;
      logic [11:0]          q_y;
      logic                 far_x;
      logic                 far_y;
   } s3_type;

   function automatic axis_type axis_frames(logic signed [12:0] now, logic signed [12:0] last,
                                            logic [7:0] pos_code, logic [7:0] neg_code);
      logic signed [12:0] diff;
      axis_type           a;
      diff   = now - last;
      a.stop = (last < 13'sd0 && now > 13'sd0) || (last > 13'sd0 && now < 13'sd0)
             || (now > 13'sd0 && last > 13'sd0 && diff > TURN_STEP)
             || (now < 13'sd0 && last < 13'sd0 && diff < -TURN_STEP);
      a.dir  = now != 13'sd0;
      a.code = (now > 13'sd0) ? pos_code : neg_code;
      return a;
   endfunction

   function automatic logic [11:0] scale_sat(logic [11:0] q, logic [17:0] gain,
                                             logic [11:0] limit);
      logic [29:0] prod;
      logic [13:0] s;
      prod = 30'(q) * 30'(gain);
      s    = prod[29:16];
      return (s > {2'b00, limit}) ? limit : s[11:0];
   endfunction

   logic               s1_v_ff, s2_v_ff, s3_v_ff;
   logic               s1_v_in, s2_v_in, s3_v_in;
   logic               s1_ready, s2_ready, s3_ready;
   req_type            s1_ff;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   logic signed [12:0] prev_dx_ff, prev_dy_ff, prev_dx_in, prev_dy_in;

   logic signed [12:0] dx, dy;
   logic signed [15:0] num_x, num_y, abs_x, abs_y;
   logic [10:0]        ax, ay;
   logic               skip, dead, upd, s1_adv;
   axis_type           axx, axy, first, second;
   logic               sec_en;
   logic [28:0]        div_x, div_y;

   assign s3_ready      = !s3_v_ff || plan_ready;
   assign s2_ready      = !s2_v_ff || s3_ready;
   assign s1_ready      = !s1_v_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign s1_adv        = s1_v_ff && s2_ready;

   assign s1_v_in = s1_ready ? req_bus.valid : s1_v_ff;
   assign s2_v_in = s2_ready ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_ready ? s2_v_ff : s3_v_ff;

   // stage 1: displacement, classification and frame slots
   always_comb begin
      dx    = 13'({2'b00, s1_ff.new_x}) - 13'({2'b00, s1_ff.old_x});
      dy    = 13'({2'b00, s1_ff.new_y}) - 13'({2'b00, s1_ff.old_y});
      ax    = dx[12] ? 11'(-dx) : dx[10:0];
      ay    = dy[12] ? 11'(-dy) : dy[10:0];
      num_x = {{3{dx[12]}}, dx} * 16'sd6 - {{3{prev_dx_ff[12]}}, prev_dx_ff};
      num_y = {{3{dy[12]}}, dy} * 16'sd6 - {{3{prev_dy_ff[12]}}, prev_dy_ff};
      abs_x = num_x[15] ? -num_x : num_x;
      abs_y = num_y[15] ? -num_y : num_y;

      skip = (s1_ff.frame_number == FN_IGNORE) || (s1_ff.frame_number == FN_PRIME);
      dead = (ax < {3'b000, cfg.dead_zone}) && (ay < {3'b000, cfg.dead_zone});
      upd  = (s1_ff.frame_number == FN_PRIME) || (!skip && !dead);

      axx = axis_frames(dx, prev_dx_ff, DIR_RIGHT, DIR_LEFT);
      axy = axis_frames(dy, prev_dy_ff, DIR_DOWN, DIR_UP);
      if (ax < ay) begin
         first  = axx;
         second = axy;
         sec_en = 1'b1;
      end else begin
         first  = axy;
         second = axx;
         sec_en = ax != ay;
      end

      s2_in.mag_x = abs_x[13:0];
      s2_in.mag_y = abs_y[13:0];
      s2_in.far_x = !(ax < {3'b000, cfg.gain_switch});
      s2_in.far_y = !(ay < {3'b000, cfg.gain_switch});
      for (int i = 0; i < NSLOT; i++) begin
         s2_in.slots[i] = '{en: 1'b0, kind: FRM_STOP, code: BYTE_NUL};
      end
      if (!skip && dead) begin
         s2_in.slots[0].en = 1'b1;
      end else if (!skip) begin
         s2_in.slots[0] = '{en: 1'b1, kind: FRM_PAN, code: BYTE_NUL};
         s2_in.slots[1] = '{en: 1'b1, kind: FRM_TILT, code: BYTE_NUL};
         s2_in.slots[2] = '{en: first.stop, kind: FRM_STOP, code: BYTE_NUL};
         s2_in.slots[3] = '{en: first.dir, kind: FRM_DIR, code: first.code};
         s2_in.slots[4] = '{en: second.stop && sec_en, kind: FRM_STOP, code: BYTE_NUL};
         s2_in.slots[5] = '{en: second.dir && sec_en, kind: FRM_DIR, code: second.code};
      end

      prev_dx_in = prev_dx_ff;
      prev_dy_in = prev_dy_ff;
      if (s1_adv && upd) begin
         prev_dx_in = dx;
         prev_dy_in = dy;
      end
   end

   // stage 2: magnitude of the predicted set point divided by five
   always_comb begin
      div_x       = 29'(s2_ff.mag_x) * 29'(DIV5_RECIP);
      div_y       = 29'(s2_ff.mag_y) * 29'(DIV5_RECIP);
      s3_in.slots = s2_ff.slots;
      s3_in.q_x   = div_x[27:16];
      s3_in.q_y   = div_y[27:16];
      s3_in.far_x = s2_ff.far_x;
      s3_in.far_y = s2_ff.far_y;
   end

   // stage 3: gain and limit
   always_comb begin
      plan.slots     = s3_ff.slots;
      plan.pan_rate  = scale_sat(s3_ff.q_x,
                                 s3_ff.far_x ? cfg.pan_gain_far : cfg.pan_gain_near,
                                 cfg.pan_speed_limit);
      plan.tilt_rate = scale_sat(s3_ff.q_y,
                                 s3_ff.far_y ? cfg.tilt_gain_far : cfg.tilt_gain_near,
                                 cfg.tilt_speed_limit);
   end
   assign plan_valid = s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         prev_dx_ff <= 13'sd1;
         prev_dy_ff <= 13'sd1;
      end else begin
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         s3_v_ff    <= s3_v_in;
         prev_dx_ff <= prev_dx_in;
         prev_dy_ff <= prev_dy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= '{old_x: req_bus.old_x, old_y: req_bus.old_y, new_x: req_bus.new_x,
                    new_y: req_bus.new_y, frame_number: req_bus.frame_number};
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$stable(prev_dx_ff) |-> $past(s1_adv))
      else $error("last displacement changed without a stage 1 advance");
`endif

endmodule

[design/ptc_emit.sv]
`timescale 1ns / 1ps
// Command byte sequencer: walks the frame plan and drives the response register.
module ptc_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              plan_valid,
   output logic              plan_ready,
   input  ptc_pkg::plan_type plan,
   ptc_rsp_if.source         rsp_bus
);
   import ptc_pkg::*;

   localparam logic [3:0] LAST_STOP  = 4'd7;
   localparam logic [3:0] LAST_DIR   = 4'd6;
   localparam logic [3:0] LAST_SPEED = 4'd8;

   function automatic logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
   endfunction

   function automatic logic [7:0] frame_byte(slot_type s, logic [3:0] idx, logic [11:0] spd);
      logic [7:0] b;
      b = BYTE_END;
      case (idx)
         4'd0: b = BYTE_SYNC;
         4'd1: b = BYTE_ADDR;
         4'd2: b = BYTE_ADDR;
         4'd3: b = BYTE_NUL;
         4'd4: begin
            case (s.kind)
               FRM_STOP: b = BYTE_STOP;
               FRM_PAN:  b = BYTE_PAN;
               FRM_TILT: b = BYTE_TILT;
               FRM_DIR:  b = BYTE_DIR;
               default:  b = BYTE_STOP;
            endcase
         end
         4'd5: begin
            case (s.kind)
               FRM_DIR:  b = s.code;
               FRM_STOP: b = BYTE_ADDR;
               default:  b = hex_char(spd[11:8]);
            endcase
         end
         4'd6: begin
            case (s.kind)
               FRM_DIR:  b = BYTE_END;
               FRM_STOP: b = BYTE_ADDR;
               default:  b = hex_char(spd[7:4]);
            endcase
         end
         4'd7: begin
            case (s.kind)
               FRM_PAN:  b = hex_char(spd[3:0]);
               FRM_TILT: b = hex_char(spd[3:0]);
               default:  b = BYTE_END;
            endcase
         end
         default: b = BYTE_END;
      endcase
      return b;
   endfunction

   logic                plan_v_ff, plan_v_in;
   plan_type            plan_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [3:0]          byte_ff, byte_in;
   logic                rsp_v_ff, rsp_v_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SLOT_W-1:0]   cur;
   logic                found, any_after, out_free, emit, frame_last, plan_done, load;
   slot_type            cur_slot;
   logic [3:0]          last_idx;
   logic [11:0]         cur_spd;

   always_comb begin
      found     = 1'b0;
      any_after = 1'b0;
      cur       = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (plan_ff.slots[i].en && SLOT_W'(i) >= slot_ff) begin
            if (!found) begin
               found = 1'b1;
               cur   = SLOT_W'(i);
            end else begin
               any_after = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cur_slot = plan_ff.slots[cur];
      cur_spd  = (cur_slot.kind == FRM_PAN) ? plan_ff.pan_rate : plan_ff.tilt_rate;
      case (cur_slot.kind)
         FRM_STOP: last_idx = LAST_STOP;
         FRM_DIR:  last_idx = LAST_DIR;
         default:  last_idx = LAST_SPEED;
      endcase
      frame_last = byte_ff == last_idx;
      out_free   = !rsp_v_ff || rsp_bus.ready;
      emit       = plan_v_ff && found && out_free;
      plan_done  = plan_v_ff && (!found || (emit && frame_last && !any_after));
      plan_ready = !plan_v_ff || plan_done;
      load       = plan_valid && plan_ready;

      plan_v_in = load ? 1'b1 : (plan_done ? 1'b0 : plan_v_ff);
      slot_in   = slot_ff;
      byte_in   = byte_ff;
      if (emit) begin
         if (frame_last) begin
            slot_in = cur + SLOT_W'(1);
            byte_in = '0;
         end else begin
            byte_in = byte_ff + 4'd1;
         end
      end
      if (load) begin
         slot_in = '0;
         byte_in = '0;
      end

      rsp_in.command_byte = frame_byte(cur_slot, byte_ff, cur_spd);
      rsp_in.frame_end    = frame_last;
      rsp_in.run_end      = frame_last && !any_after;
      rsp_v_in = emit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         slot_ff   <= '0;
         byte_ff   <= '0;
      end else begin
         plan_v_ff <= plan_v_in;
         rsp_v_ff  <= rsp_v_in;
         slot_ff   <= slot_in;
         byte_ff   <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff <= plan;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_v_ff;
   assign rsp_bus.command_byte = rsp_ff.command_byte;
   assign rsp_bus.frame_end    = rsp_ff.frame_end;
   assign rsp_bus.run_end      = rsp_ff.run_end;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.run_end |-> rsp_ff.frame_end)
      else $error("run end on a beat that does not close a frame");
   assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.frame_end |-> rsp_ff.command_byte == BYTE_END)
      else $error("frame end flagged on a byte other than the terminator");
`endif

endmodule

[design/pan_tilt_tracking_command_controller.sv]
`timescale 1ns / 1ps
// Top level of the pan/tilt tracking command controller.
//
//   channel  | dir | beat                                          | handshake
//   req_bus  | in  | old_x, old_y, new_x, new_y, frame_number      | valid/ready
//   rsp_bus  | out | command_byte, frame_end, run_end              | valid/ready
//   csr_*    | in  | csr_index, csr_wdata                          | csr_we, no wait
//
// A request passes a three-stage pipeline and the plan register before its first
// beat, then one byte per cycle: 7 to 9 bytes per command frame, up to 48 bytes
// per request; the byte sequencer sets the rate. A request with no bytes occupies
// the sequencer. Requests keep entering the pipeline while earlier bytes are sent.
// Reset is synchronous: clears valids, loads register defaults, last displacement 1.
// rsp ready low holds the response beat and backs the pipeline up to req ready.
module pan_tilt_tracking_command_controller (
   input  logic                             clock,
   input  logic                             reset,
   ptc_req_if.sink                          req_bus,
   ptc_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ptc_pkg::*;

   cfg_type  cfg;
   plan_type plan;
   logic     plan_valid;
   logic     plan_ready;

   ptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptc_plan u_plan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_bus    (req_bus),
      .plan_valid (plan_valid),
      .plan_ready (plan_ready),
      .plan       (plan)
   );

   ptc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (plan_valid),
      .plan_ready (plan_ready),
      .plan       (plan),
      .rsp_bus    (rsp_bus)
   );

endmodule
